// ===== rtl/oad_pkg.sv =====
// Shared codes, widths and result control type for the ordered list block.
package oad_pkg;

    localparam int DEF_CAPACITY   = 16;
    localparam int DEF_VALUE_BITS = 32;

    localparam int CMD_BITS    = 2;
    localparam int STATUS_BITS = 2;
    localparam int OCC_BITS    = 5;

    localparam logic [CMD_BITS-1:0] CMD_APPEND   = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_DELETE   = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_LIST_FWD = 2'd2;
    localparam logic [CMD_BITS-1:0] CMD_LIST_BWD = 2'd3;

    localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic                   last;
        logic [OCC_BITS-1:0]    occupancy;
    } t_res_ctl;

endpackage

// ===== rtl/oad_in_if.sv =====
// Command channel interface: valid, ready, command and value.
interface oad_in_if #(
    parameter int VALUE_BITS = oad_pkg::DEF_VALUE_BITS
);
    import oad_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [CMD_BITS-1:0]          command;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

// ===== rtl/oad_out_if.sv =====
// Result channel interface: valid, ready, status, entry, last and occupancy.
interface oad_out_if #(
    parameter int VALUE_BITS = oad_pkg::DEF_VALUE_BITS
);
    import oad_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [STATUS_BITS-1:0]       status;
    logic signed [VALUE_BITS-1:0] entry;
    logic                         last;
    logic [OCC_BITS-1:0]          occupancy;

    modport source (output valid, output status, output entry, output last,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input entry, input last,
                    input occupancy, output ready);
endinterface

// ===== rtl/ordered_list_append_delete.sv =====
// Ordered list of bounded capacity with append, delete and listings.
//
// Commands enter on i_in (command, value); results leave on o_out
// (status, entry, last, occupancy). Each command yields one or more
// results; the final one of each command carries last.
// Append, and any command on an empty list, is accepted and its result is
// loaded into the output register in the same cycle.
// Delete primes a memory read in its accept cycle, then compares one stored
// entry per cycle through a single comparator; on a match it closes the gap
// by pulling each later entry down one place, and a miss scans every entry.
// A listing primes one memory read, then gives one result per cycle while
// the receiver takes them. The slot memory has a single read port.
// i_in.ready is low while a command is in progress and while the output
// register holds a transaction that the receiver has not taken.
// Reset clears the fill count and the sequencer; slot contents are kept
// and never read before being written. When the receiver stalls, the
// output register holds its transaction; the sequencer waits to push.
module ordered_list_append_delete #(
    parameter int CAPACITY   = oad_pkg::DEF_CAPACITY,
    parameter int VALUE_BITS = oad_pkg::DEF_VALUE_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    oad_in_if.sink     i_in,
    oad_out_if.source  o_out
);
    import oad_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic                  can_push;
    logic                  push;
    t_res_ctl              push_ctl;
    logic [VALUE_BITS-1:0] push_entry;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [VALUE_BITS-1:0] wr_data;
    logic [AW-1:0]         rd_addr;
    logic [VALUE_BITS-1:0] rd_data;

    logic                  r_out_valid;
    t_res_ctl              r_out_ctl;
    logic [VALUE_BITS-1:0] r_out_entry;

    assign can_push = !r_out_valid || o_out.ready;

    oad_ctrl #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (i_in.valid),
        .i_cmd        (i_in.command),
        .i_value      (i_in.value),
        .o_cmd_ready  (i_in.ready),
        .i_can_push   (can_push),
        .o_push       (push),
        .o_push_ctl   (push_ctl),
        .o_push_entry (push_entry),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data)
    );

    oad_slot_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_BITS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // output register: load on push, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (push) begin
            r_out_ctl   <= push_ctl;
            r_out_entry <= push_entry;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.status    = r_out_ctl.status;
    assign o_out.last      = r_out_ctl.last;
    assign o_out.occupancy = r_out_ctl.occupancy;
    assign o_out.entry     = r_out_entry;
endmodule

// ===== rtl/oad_slot_ram.sv =====
// Slot memory: one write port, one read port with registered read data.
module oad_slot_ram #(
    parameter int DEPTH = oad_pkg::DEF_CAPACITY,
    parameter int WIDTH = oad_pkg::DEF_VALUE_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== rtl/oad_ctrl.sv =====
// Sequencer: walks the slot memory one entry a cycle while not stalled; one compare unit serves delete.
module oad_ctrl #(
    parameter int CAPACITY   = oad_pkg::DEF_CAPACITY,
    parameter int VALUE_BITS = oad_pkg::DEF_VALUE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  logic [oad_pkg::CMD_BITS-1:0]  i_cmd,
    input  logic [VALUE_BITS-1:0]         i_value,
    output logic                          o_cmd_ready,
    input  logic                          i_can_push,
    output logic                          o_push,
    output oad_pkg::t_res_ctl             o_push_ctl,
    output logic [VALUE_BITS-1:0]         o_push_entry,
    output logic                          o_wr_en,
    output logic [$clog2(CAPACITY)-1:0]   o_wr_addr,
    output logic [VALUE_BITS-1:0]         o_wr_data,
    output logic [$clog2(CAPACITY)-1:0]   o_rd_addr,
    input  logic [VALUE_BITS-1:0]         i_rd_data
);
    import oad_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_LIST  = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_idx, n_idx;
    logic [CW-1:0]         r_pos, n_pos;
    logic [VALUE_BITS-1:0] r_key, n_key;
    logic                  r_back, n_back;

    logic          accept;
    logic          hit;
    logic          at_end;
    logic          shift_done;
    logic [CW-1:0] idx_ext;

    assign o_cmd_ready = (r_state == S_IDLE) && i_can_push;
    assign accept      = i_cmd_valid && o_cmd_ready;
    assign idx_ext     = CW'(r_idx);
    assign hit         = (i_rd_data == r_key);
    assign at_end      = ((idx_ext + CW'(1)) == r_count);
    assign shift_done  = ((idx_ext + CW'(2)) == r_count);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_key        = r_key;
        n_back       = r_back;
        o_push       = 1'b0;
        o_push_ctl   = '{status: ST_OK, last: 1'b1, occupancy: OCC_BITS'(r_count)};
        o_push_entry = '0;
        o_wr_en      = 1'b0;
        o_wr_addr    = r_idx;
        o_wr_data    = i_rd_data;
        o_rd_addr    = r_idx;
        case (r_state)
            S_IDLE: begin
                o_rd_addr = '0;
                if (accept) begin
                    case (i_cmd)
                        CMD_APPEND: begin
                            o_push = 1'b1;
                            if (r_count == CAP_C) begin
                                o_push_ctl.status = ST_FULL;
                            end else begin
                                o_wr_en   = 1'b1;
                                o_wr_addr = AW'(r_count);
                                o_wr_data = i_value;
                                n_count   = r_count + CW'(1);
                                o_push_ctl.occupancy = OCC_BITS'(n_count);
                            end
                        end
                        CMD_DELETE: begin
                            if (r_count == '0) begin
                                o_push = 1'b1;
                                o_push_ctl.status = ST_NOT_FOUND;
                            end else begin
                                n_key     = i_value;
                                n_idx     = '0;
                                o_rd_addr = '0;
                                n_state   = S_SCAN;
                            end
                        end
                        default: begin
                            if (r_count == '0) begin
                                o_push = 1'b1;
                                o_push_ctl.status = ST_EMPTY;
                            end else begin
                                n_back    = (i_cmd == CMD_LIST_BWD);
                                n_pos     = '0;
                                n_idx     = n_back ? AW'(r_count - CW'(1)) : '0;
                                o_rd_addr = n_idx;
                                n_state   = S_LIST;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (hit && at_end) begin
                    if (i_can_push) begin
                        o_push  = 1'b1;
                        n_count = r_count - CW'(1);
                        o_push_ctl.occupancy = OCC_BITS'(n_count);
                        n_state = S_IDLE;
                    end
                end else if (hit) begin
                    // fetch the successor, then pull entries down one place a cycle
                    o_rd_addr = r_idx + AW'(1);
                    n_state   = S_SHIFT;
                end else if (at_end) begin
                    if (i_can_push) begin
                        o_push = 1'b1;
                        o_push_ctl.status = ST_NOT_FOUND;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_idx     = r_idx + AW'(1);
                    o_rd_addr = n_idx;
                end
            end
            S_SHIFT: begin
                o_rd_addr = r_idx + AW'(1);
                if (!shift_done) begin
                    o_wr_en   = 1'b1;
                    n_idx     = r_idx + AW'(1);
                    o_rd_addr = r_idx + AW'(2);
                end else if (i_can_push) begin
                    o_wr_en = 1'b1;
                    o_push  = 1'b1;
                    n_count = r_count - CW'(1);
                    o_push_ctl.occupancy = OCC_BITS'(n_count);
                    n_state = S_IDLE;
                end
            end
            S_LIST: begin
                if (i_can_push) begin
                    o_push          = 1'b1;
                    o_push_entry    = i_rd_data;
                    o_push_ctl.last = ((r_pos + CW'(1)) == r_count);
                    if (o_push_ctl.last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_pos     = r_pos + CW'(1);
                        n_idx     = r_back ? (r_idx - AW'(1)) : (r_idx + AW'(1));
                        o_rd_addr = n_idx;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_idx  <= n_idx;
        r_pos  <= n_pos;
        r_key  <= n_key;
        r_back <= n_back;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("fill count above capacity");

    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_push_ctl.status == ST_FULL) |-> (r_count == CAP_C))
        else $error("full status with free slots");

    a_last_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_push_ctl.last) |=> (r_state == S_IDLE))
        else $error("sequencer busy after final result");

    a_shift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wr_en && r_state == S_SHIFT) |-> ((idx_ext + CW'(2)) <= r_count))
        else $error("shift write beyond occupied slots");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd == CMD_APPEND && r_count != CAP_C)
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("append did not grow the list");
endmodule

// ===== dv/tb_ordered_list_append_delete.sv =====
// Self-checking testbench for the ordered list block: directed and random commands.
module tb_ordered_list_append_delete;
    timeunit 1ns;
    timeprecision 1ps;

    import oad_pkg::*;

    localparam int CAPACITY     = DEF_CAPACITY;
    localparam int VALUE_BITS   = DEF_VALUE_BITS;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 40;
    localparam int IDLE_PCT     = 7;

    typedef logic signed [VALUE_BITS-1:0] t_list_value;

    typedef struct {
        logic [STATUS_BITS-1:0] status;
        t_list_value            entry;
        logic                   last;
        logic [OCC_BITS-1:0]    occupancy;
    } t_list_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    oad_in_if  #(.VALUE_BITS(VALUE_BITS)) cmd_if ();
    oad_out_if #(.VALUE_BITS(VALUE_BITS)) res_if ();

    ordered_list_append_delete #(
        .CAPACITY  (CAPACITY),
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (cmd_if),
        .o_out  (res_if)
    );

    // Shadow copy of the list, advanced on every accepted command
    t_list_value  list_slots [CAPACITY];
    int           list_fill = 0;
    t_list_result pending_results [$];

    int error_count = 0;
    int cycle_count = 0;
    int hold_cycles = 0;
    bit cmd_idle_on = 1'b1;
    bit res_idle_on = 1'b1;

    always #10 i_clk = ~i_clk;

    task automatic report_error(input string msg);
        $display("%0t ERROR: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic void push_result(input logic [STATUS_BITS-1:0] status,
                                        input t_list_value entry, input logic last);
        t_list_result r;
        r.status    = status;
        r.entry     = entry;
        r.last      = last;
        r.occupancy = OCC_BITS'(list_fill);
        pending_results.push_back(r);
    endfunction

    function automatic void predict_list_command(input logic [CMD_BITS-1:0] cmd,
                                                 input t_list_value val);
        int hit;
        case (cmd)
            CMD_APPEND: begin
                if (list_fill >= CAPACITY) begin
                    push_result(ST_FULL, '0, 1'b1);
                end else begin
                    list_slots[list_fill] = val;
                    list_fill++;
                    push_result(ST_OK, '0, 1'b1);
                end
            end
            CMD_DELETE: begin
                hit = -1;
                for (int i = 0; i < list_fill; i++) begin
                    if (hit < 0 && list_slots[i] == val) hit = i;
                end
                if (hit < 0) begin
                    push_result(ST_NOT_FOUND, '0, 1'b1);
                end else begin
                    // close the gap toward the head
                    for (int i = hit; i + 1 < list_fill; i++) list_slots[i] = list_slots[i + 1];
                    list_fill--;
                    push_result(ST_OK, '0, 1'b1);
                end
            end
            default: begin
                if (list_fill == 0) begin
                    push_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    for (int i = 0; i < list_fill; i++) begin
                        push_result(ST_OK,
                                    (cmd == CMD_LIST_FWD) ? list_slots[i]
                                                          : list_slots[list_fill - 1 - i],
                                    (i + 1 == list_fill));
                    end
                end
            end
        endcase
    endfunction

    // Call at a falling edge; returns at the falling edge after the transaction
    task automatic send_command(input logic [CMD_BITS-1:0] cmd, input t_list_value val);
        while (cmd_idle_on && $urandom_range(99) < IDLE_PCT) begin
            cmd_if.valid = 1'b0;
            @(negedge i_clk);
        end
        cmd_if.valid   = 1'b1;
        cmd_if.command = cmd;
        cmd_if.value   = val;
        do @(posedge i_clk); while (!cmd_if.ready);
        predict_list_command(cmd, val);
        @(negedge i_clk);
    endtask

    function automatic t_list_value random_value();
        case ($urandom_range(3))
            0: begin
                case ($urandom_range(3))
                    0: return -1;
                    1: return 0;
                    2: return 1;
                    default: return 7;
                endcase
            end
            1: return $urandom_range(1) ? {1'b1, {(VALUE_BITS-1){1'b0}}}
                                         : {1'b0, {(VALUE_BITS-1){1'b1}}};
            default: return $urandom;
        endcase
    endfunction

    task automatic test_empty_list();
        send_command(CMD_LIST_FWD, random_value());
        send_command(CMD_LIST_BWD, random_value());
        send_command(CMD_DELETE, 0);
    endtask

    task automatic test_fill_and_delete();
        // duplicates of -1 check that delete takes the first match
        t_list_value fill_vals [CAPACITY] = '{
            {1'b1, {(VALUE_BITS-1){1'b0}}}, -1, 0, 5, -1, {1'b0, {(VALUE_BITS-1){1'b1}}},
            32'h5555_5555, 32'hAAAA_AAAA, 100, -100, 1, 2, 3, 4, 5, 32'h1234_5678};
        foreach (fill_vals[i]) send_command(CMD_APPEND, fill_vals[i]);
        send_command(CMD_APPEND, 99);
        send_command(CMD_LIST_FWD, 0);
        send_command(CMD_LIST_BWD, 0);
        send_command(CMD_DELETE, {1'b1, {(VALUE_BITS-1){1'b0}}});
        send_command(CMD_DELETE, -1);
        send_command(CMD_DELETE, 32'h1234_5678);
        send_command(CMD_DELETE, 12345);
        send_command(CMD_LIST_FWD, 0);
    endtask

    task automatic test_random_mix(input int count, input int append_pct);
        int roll;
        logic [CMD_BITS-1:0] cmd;
        t_list_value val;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < append_pct) cmd = CMD_APPEND;
            else if (roll < append_pct + (100 - append_pct) / 2) cmd = CMD_DELETE;
            else if (roll % 2 == 0) cmd = CMD_LIST_FWD;
            else cmd = CMD_LIST_BWD;
            val = random_value();
            // most deletes aim at a stored key
            if (cmd == CMD_DELETE && list_fill != 0 && $urandom_range(99) < 75) begin
                val = list_slots[$urandom_range(list_fill - 1)];
            end
            send_command(cmd, val);
        end
    endtask

    task automatic test_back_to_back();
        cmd_idle_on = 1'b0;
        res_idle_on = 1'b0;
        test_random_mix(30, 40);
        cmd_idle_on = 1'b1;
        res_idle_on = 1'b1;
    endtask

    task automatic test_output_hold();
        hold_cycles = 150;
        send_command(CMD_APPEND, random_value());
        send_command(CMD_APPEND, random_value());
        send_command(CMD_LIST_FWD, 0);
        send_command(CMD_DELETE, list_slots[0]);
        send_command(CMD_LIST_BWD, 0);
        test_random_mix(5, 50);
    endtask

    // Result receiver: random stalls plus a long hold on request
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                res_if.ready = 1'b0;
                hold_cycles--;
            end else begin
                res_if.ready = !(res_idle_on && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_list_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                report_error($sformatf("result with nothing pending: status %0d entry %0d",
                                       res_if.status, res_if.entry));
            end else begin
                want = pending_results.pop_front();
                if (res_if.status !== want.status)
                    report_error($sformatf("status: expected %0d got %0d",
                                           want.status, res_if.status));
                if (res_if.entry !== want.entry)
                    report_error($sformatf("entry: expected %0d got %0d",
                                           want.entry, res_if.entry));
                if (res_if.last !== want.last)
                    report_error($sformatf("last: expected %0d got %0d",
                                           want.last, res_if.last));
                if (res_if.occupancy !== want.occupancy)
                    report_error($sformatf("occupancy: expected %0d got %0d",
                                           want.occupancy, res_if.occupancy));
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_ordered_list_append_delete: FAIL");
        $finish;
    end

    initial begin
        cmd_if.valid   = 1'b0;
        cmd_if.command = CMD_APPEND;
        cmd_if.value   = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_empty_list();
        test_fill_and_delete();
        test_random_mix(25, 60);
        test_output_hold();
        test_back_to_back();
        test_random_mix(15, 25);

        cmd_if.valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_ordered_list_append_delete: PASS");
        end else begin
            $display("tb_ordered_list_append_delete: FAIL");
        end
        $finish;
    end

endmodule
